### rtl/core/tpah_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle perimeter and area package
// Widths, status codes and request/response types shared by the block.
// ----------------------------------------------------------------------------
package tpah_pkg;

	localparam int COORD_BITS = 12;

	// Coordinate difference, squared-distance and edge-root widths.
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int D2_W   = 2 * DIFF_W - 1;
	localparam int ER_W   = DIFF_W + 8;
	// Perimeter sum, Heron product and its square root.
	localparam int PW     = ER_W + 2;
	localparam int QR_W   = 2 * PW;
	localparam int Q_W    = 4 * PW;

	localparam int PERIM_W  = 23;
	localparam int AREA_W   = 39;
	localparam int STATUS_W = 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_COINCIDENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_COLLINEAR  = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by_coord;
		coord_t cx;
		coord_t cy;
	} tri_req_t;

	typedef struct packed {
		logic [PERIM_W-1:0]  perimeter;
		logic [AREA_W-1:0]   area;
		logic [STATUS_W-1:0] status;
	} tri_rsp_t;

	typedef struct packed {
		tri_req_t            vtx;
		logic [STATUS_W-1:0] status;
	} tri_cls_t;

endpackage

### rtl/core/tpah_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle classifier
// Accepts requests and tags each with coincident/collinear status.
// ----------------------------------------------------------------------------
module tpah_front import tpah_pkg::*; (
	input  logic     in_valid,
	input  tri_req_t req,
	input  logic     q_full,
	output logic     in_stall,
	output logic     push,
	output tri_cls_t cls
);

	logic signed [DIFF_W-1:0]   e1x, e1y, e2x, e2y;
	logic signed [2*DIFF_W-1:0] p1, p2;
	logic                       coincident;

	assign e1x = DIFF_W'(req.bx) - DIFF_W'(req.ax);
	assign e1y = DIFF_W'(req.by_coord) - DIFF_W'(req.ay);
	assign e2x = DIFF_W'(req.cx) - DIFF_W'(req.ax);
	assign e2y = DIFF_W'(req.cy) - DIFF_W'(req.ay);

	// The cross product is zero exactly when both partial products agree.
	assign p1 = e1x * e2y;
	assign p2 = e1y * e2x;

	assign coincident = (req.ax == req.bx && req.ay == req.by_coord) ||
		(req.bx == req.cx && req.by_coord == req.cy) ||
		(req.ax == req.cx && req.ay == req.cy);

	always_comb begin
		cls.vtx = req;
		if (coincident) begin
			cls.status = ST_COINCIDENT;
		end else if (p1 == p2) begin
			cls.status = ST_COLLINEAR;
		end else begin
			cls.status = ST_OK;
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

### rtl/core/tpah_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classified request queue
// Small FIFO that decouples the classifier from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module tpah_queue import tpah_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tri_cls_t push_cls,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output tri_cls_t head_cls
);

	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	tri_cls_t          mem_q [0:QUEUE_DEPTH-1];

	assign full       = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_cls   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cls;
		end
	end

endmodule

### rtl/core/tpah_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle arithmetic pipeline
// Edge roots, perimeter, Heron product and its root; the roots take one bit per stage.
// ----------------------------------------------------------------------------
module tpah_back import tpah_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	input  tri_cls_t src_cls,
	output logic     src_pop,
	output logic     out_valid,
	input  logic     out_stall,
	output tri_rsp_t out_rsp
);

	logic adv;

	// The whole pipeline holds while a finished result is not taken.
	assign adv     = !(out_valid && out_stall);
	assign src_pop = src_valid && adv;

	// ---------------- edge square roots ----------------
	logic                      e_v_s    [0:ER_W];
	logic [STATUS_W-1:0]       e_st_s   [0:ER_W];
	logic [D2_W-1:0]           e_d2_s   [0:ER_W][0:2];
	logic [ER_W:0]             e_rem_s  [0:ER_W][0:2];
	logic [ER_W-1:0]           e_root_s [0:ER_W][0:2];

	logic signed [DIFF_W-1:0]   dx [0:2];
	logic signed [DIFF_W-1:0]   dy [0:2];
	logic signed [2*DIFF_W-1:0] sqx [0:2];
	logic signed [2*DIFF_W-1:0] sqy [0:2];
	logic [D2_W-1:0]            d2_in [0:2];

	always_comb begin
		dx[0] = DIFF_W'(src_cls.vtx.ax) - DIFF_W'(src_cls.vtx.bx);
		dy[0] = DIFF_W'(src_cls.vtx.ay) - DIFF_W'(src_cls.vtx.by_coord);
		dx[1] = DIFF_W'(src_cls.vtx.bx) - DIFF_W'(src_cls.vtx.cx);
		dy[1] = DIFF_W'(src_cls.vtx.by_coord) - DIFF_W'(src_cls.vtx.cy);
		dx[2] = DIFF_W'(src_cls.vtx.ax) - DIFF_W'(src_cls.vtx.cx);
		dy[2] = DIFF_W'(src_cls.vtx.ay) - DIFF_W'(src_cls.vtx.cy);
		for (int i = 0; i < 3; i++) begin
			sqx[i]   = dx[i] * dx[i];
			sqy[i]   = dy[i] * dy[i];
			d2_in[i] = D2_W'($unsigned(sqx[i])) + D2_W'($unsigned(sqy[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_v_s[0] <= 1'b0;
		end else if (adv) begin
			e_v_s[0] <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_st_s[0] <= src_cls.status;
			for (int i = 0; i < 3; i++) begin
				e_d2_s[0][i]   <= d2_in[i];
				e_rem_s[0][i]  <= '0;
				e_root_s[0][i] <= '0;
			end
		end
	end

	for (genvar k = 0; k < ER_W; k++) begin : g_edge
		logic [2*ER_W-1:0] rad   [0:2];
		logic [ER_W+2:0]   tmp   [0:2];
		logic [ER_W+2:0]   trial [0:2];
		logic [ER_W+2:0]   diff  [0:2];
		logic              ge    [0:2];

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rad[i]   = {1'b0, e_d2_s[k][i], 16'b0};
				tmp[i]   = {e_rem_s[k][i], rad[i][2*ER_W-1-2*k -: 2]};
				trial[i] = {1'b0, e_root_s[k][i], 2'b01};
				ge[i]    = tmp[i] >= trial[i];
				diff[i]  = tmp[i] - trial[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				e_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				e_v_s[k+1] <= e_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				e_st_s[k+1] <= e_st_s[k];
				for (int i = 0; i < 3; i++) begin
					e_d2_s[k+1][i]   <= e_d2_s[k][i];
					e_rem_s[k+1][i]  <= ge[i] ? diff[i][ER_W:0] : tmp[i][ER_W:0];
					e_root_s[k+1][i] <= {e_root_s[k][i][ER_W-2:0], ge[i]};
				end
			end
		end
	end

	// ---------------- perimeter ----------------
	logic                v_s23;
	logic [STATUS_W-1:0] st_s23;
	logic [PW-1:0]       p_s23;
	logic [ER_W-1:0]     ed_s23 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s23 <= 1'b0;
		end else if (adv) begin
			v_s23 <= e_v_s[ER_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s23 <= e_st_s[ER_W];
			p_s23  <= PW'(e_root_s[ER_W][0]) + PW'(e_root_s[ER_W][1]) +
				PW'(e_root_s[ER_W][2]);
			for (int i = 0; i < 3; i++) begin
				ed_s23[i] <= e_root_s[ER_W][i];
			end
		end
	end

	// ---------------- Heron factors ----------------
	logic signed [PW:0] fs   [0:2];
	logic               fneg [0:2];
	logic               fzer [0:2];
	logic [PW:0]        fabs [0:2];

	logic                v_s24;
	logic [STATUS_W-1:0] st_s24;
	logic [PW-1:0]       p_s24;
	logic [PW-1:0]       fa_s24 [0:2];
	logic                qz_s24;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fs[i]   = $signed({1'b0, p_s23}) - $signed({2'b0, ed_s23[i], 1'b0});
			fneg[i] = fs[i][PW];
			fzer[i] = fs[i] == '0;
			fabs[i] = fneg[i] ? $unsigned(-fs[i]) : $unsigned(fs[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s24 <= 1'b0;
		end else if (adv) begin
			v_s24 <= v_s23;
		end
	end

	// A zero factor or an odd count of negative factors gives Q of zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			st_s24 <= st_s23;
			p_s24  <= p_s23;
			qz_s24 <= (p_s23 == '0) || fzer[0] || fzer[1] || fzer[2] ||
				(fneg[0] ^ fneg[1] ^ fneg[2]);
			for (int i = 0; i < 3; i++) begin
				fa_s24[i] <= fabs[i][PW-1:0];
			end
		end
	end

	// ---------------- pair products ----------------
	logic                v_s25;
	logic [STATUS_W-1:0] st_s25;
	logic [PW-1:0]       p_s25;
	logic                qz_s25;
	logic [2*PW-1:0]     m1_s25, m2_s25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s25 <= 1'b0;
		end else if (adv) begin
			v_s25 <= v_s24;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s25 <= st_s24;
			p_s25  <= p_s24;
			qz_s25 <= qz_s24;
			m1_s25 <= (2*PW)'(p_s24) * (2*PW)'(fa_s24[0]);
			m2_s25 <= (2*PW)'(fa_s24[1]) * (2*PW)'(fa_s24[2]);
		end
	end

	// ---------------- partial products of Q ----------------
	logic                v_s26;
	logic [STATUS_W-1:0] st_s26;
	logic [PW-1:0]       p_s26;
	logic                qz_s26;
	logic [2*PW-1:0]     pp_hh_s26, pp_hl_s26, pp_lh_s26, pp_ll_s26;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s26 <= 1'b0;
		end else if (adv) begin
			v_s26 <= v_s25;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s26    <= st_s25;
			p_s26     <= p_s25;
			qz_s26    <= qz_s25;
			pp_hh_s26 <= (2*PW)'(m1_s25[2*PW-1:PW]) * (2*PW)'(m2_s25[2*PW-1:PW]);
			pp_hl_s26 <= (2*PW)'(m1_s25[2*PW-1:PW]) * (2*PW)'(m2_s25[PW-1:0]);
			pp_lh_s26 <= (2*PW)'(m1_s25[PW-1:0]) * (2*PW)'(m2_s25[2*PW-1:PW]);
			pp_ll_s26 <= (2*PW)'(m1_s25[PW-1:0]) * (2*PW)'(m2_s25[PW-1:0]);
		end
	end

	// ---------------- area square root ----------------
	logic                q_v_s    [0:QR_W];
	logic [STATUS_W-1:0] q_st_s   [0:QR_W];
	logic [PW-1:0]       q_p_s    [0:QR_W];
	logic [Q_W-1:0]      q_rad_s  [0:QR_W];
	logic [QR_W:0]       q_rem_s  [0:QR_W];
	logic [QR_W-1:0]     q_root_s [0:QR_W];

	logic [Q_W-1:0] q_sum;

	assign q_sum = {pp_hh_s26, {(2*PW){1'b0}}} +
		((Q_W'(pp_hl_s26) + Q_W'(pp_lh_s26)) << PW) + Q_W'(pp_ll_s26);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_v_s[0] <= 1'b0;
		end else if (adv) begin
			q_v_s[0] <= v_s26;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_st_s[0]   <= st_s26;
			q_p_s[0]    <= p_s26;
			q_rad_s[0]  <= qz_s26 ? '0 : q_sum;
			q_rem_s[0]  <= '0;
			q_root_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < QR_W; j++) begin : g_area
		logic [QR_W+2:0] tmp, trial, diff;
		logic            ge;

		assign tmp   = {q_rem_s[j], q_rad_s[j][Q_W-1-2*j -: 2]};
		assign trial = {1'b0, q_root_s[j], 2'b01};
		assign ge    = tmp >= trial;
		assign diff  = tmp - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				q_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				q_v_s[j+1] <= q_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				q_st_s[j+1]   <= q_st_s[j];
				q_p_s[j+1]    <= q_p_s[j];
				q_rad_s[j+1]  <= q_rad_s[j];
				q_rem_s[j+1]  <= ge ? diff[QR_W:0] : tmp[QR_W:0];
				q_root_s[j+1] <= {q_root_s[j][QR_W-2:0], ge};
			end
		end
	end

	// ---------------- result ----------------
	assign out_valid      = q_v_s[QR_W];
	assign out_rsp.status = q_st_s[QR_W];
	assign out_rsp.perimeter = (q_st_s[QR_W] == ST_OK) ? PERIM_W'(q_p_s[QR_W]) : '0;
	assign out_rsp.area      = (q_st_s[QR_W] == ST_OK) ?
		AREA_W'(q_root_s[QR_W] >> 2) : '0;

	// ---------------- checks ----------------
	logic [2*ER_W:0] chk_rad, chk_lo, chk_hi;

	assign chk_rad = {2'b0, e_d2_s[ER_W][0], 16'b0};
	assign chk_lo  = (2*ER_W+1)'(e_root_s[ER_W][0]) * (2*ER_W+1)'(e_root_s[ER_W][0]);
	assign chk_hi  = ((2*ER_W+1)'(e_root_s[ER_W][0]) + 1'b1) *
		((2*ER_W+1)'(e_root_s[ER_W][0]) + 1'b1);

	a_edge_root: assert property (@(posedge clk) disable iff (!arst_n)
		e_v_s[ER_W] |-> (chk_lo <= chk_rad) && (chk_hi > chk_rad))
		else $error("edge root out of bracket");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(p_s23) && $stable(v_s26))
		else $error("pipeline moved while output stalled");

	a_valid_perim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && q_st_s[QR_W] == ST_OK |-> q_p_s[QR_W] != '0)
		else $error("proper triangle with zero perimeter");

endmodule

### rtl/core/triangle_perimeter_area_heron_top.sv
`timescale 1ns / 1ps
// Throughput: one triangle per cycle while out_stall does not hold a result; edge roots
// take one bit per stage (21 stages) and the area root one bit per stage (46 stages)
// in fully pipelined units.
// A four-entry queue after the classifier keeps accepting up to four requests while results wait.
// Reset (arst_n low, asynchronous) empties the queue and clears all stage valids.
// ----------------------------------------------------------------------------
// Triangle perimeter and Heron area
// Classifier, request queue and arithmetic pipeline.
// ----------------------------------------------------------------------------
module triangle_perimeter_area_heron_top import tpah_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  tri_req_t in_req,
	output logic     out_valid,
	input  logic     out_stall,
	output tri_rsp_t out_rsp
);

	logic     q_full, push, head_valid, pop;
	tri_cls_t push_cls, head_cls;

	tpah_front u_front (
		.in_valid (in_valid),
		.req      (in_req),
		.q_full   (q_full),
		.in_stall (in_stall),
		.push     (push),
		.cls      (push_cls)
	);

	tpah_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cls   (push_cls),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cls   (head_cls)
	);

	tpah_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (head_valid),
		.src_cls   (head_cls),
		.src_pop   (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp)
	);

endmodule
